// ===== sv/rbc_pkg.sv =====
// ----------------------------------------------------------------------------
// rbc_pkg
// Shared widths, types and codes for the byte Rabin cipher.
// ----------------------------------------------------------------------------
package rbc_pkg;

    localparam int PRIME_BITS = 11;
    localparam int N_BITS     = 22;
    localparam int BYTE_BITS  = 8;
    localparam int MUL_B_BITS = 16;
    localparam int MOD_BITS   = (2 * PRIME_BITS > N_BITS) ? 2 * PRIME_BITS : N_BITS;
    localparam int X_BITS     = (MOD_BITS + PRIME_BITS + 1 > 32) ?
                                MOD_BITS + PRIME_BITS + 1 : 32;
    localparam int EXP_BITS   = PRIME_BITS - 1;
    localparam int CNT_BITS   = $clog2(X_BITS + 1);
    localparam int PROD_BITS  = MOD_BITS + MUL_B_BITS;

    typedef logic [PRIME_BITS-1:0] prime_t;
    typedef logic [N_BITS-1:0]     word_t;
    typedef logic [MOD_BITS-1:0]   mod_t;
    typedef logic [MUL_B_BITS-1:0] mulb_t;
    typedef logic [X_BITS-1:0]     wide_t;
    typedef logic [EXP_BITS-1:0]   exp_t;
    typedef logic [CNT_BITS-1:0]   cnt_t;
    typedef logic [PROD_BITS-1:0]  prod_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mod_stat_t;

    localparam logic [1:0] CFG_PRIME_P   = 2'd0;
    localparam logic [1:0] CFG_PRIME_Q   = 2'd1;
    localparam logic [1:0] CFG_MODULUS_N = 2'd2;

    localparam prime_t RST_PRIME_P   = prime_t'(1019);
    localparam prime_t RST_PRIME_Q   = prime_t'(1031);
    localparam word_t  RST_MODULUS_N = word_t'(1050589);

endpackage

// ===== sv/rbc_mod_unit.sv =====
// ----------------------------------------------------------------------------
// rbc_mod_unit
// Restoring reducer: r = x mod m, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module rbc_mod_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  rbc_pkg::wide_t     x,
    input  rbc_pkg::mod_t      m,
    output rbc_pkg::mod_t      r,
    output rbc_pkg::mod_stat_t stat
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    rbc_pkg::cnt_t               cnt_reg, cnt_next;
    rbc_pkg::wide_t              x_reg;
    rbc_pkg::mod_t               m_reg;
    logic [rbc_pkg::MOD_BITS:0]  rem_reg;
    logic [rbc_pkg::MOD_BITS:0]  shifted;
    logic [rbc_pkg::MOD_BITS:0]  m_ext;

    assign m_ext   = {1'b0, m_reg};
    assign shifted = {rem_reg[rbc_pkg::MOD_BITS-1:0], x_reg[rbc_pkg::X_BITS-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = rbc_pkg::cnt_t'(rbc_pkg::X_BITS);
        end else if (busy_reg) begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == rbc_pkg::cnt_t'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            x_reg   <= x;
            m_reg   <= m;
            rem_reg <= '0;
        end else if (busy_reg) begin
            x_reg <= {x_reg[rbc_pkg::X_BITS-2:0], 1'b0};
            if (shifted >= m_ext) begin
                rem_reg <= shifted - m_ext;
            end else begin
                rem_reg <= shifted;
            end
        end
    end

    assign r         = rem_reg[rbc_pkg::MOD_BITS-1:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== sv/rabin_byte_cipher_top.sv =====
// ----------------------------------------------------------------------------
// rabin_byte_cipher_top
// Byte Rabin cipher: encrypt by squaring mod n, decrypt by roots and CRT.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one item (mode, plain_byte, cipher_in) per transfer;
//   m_* channel returns one result (cipher_out, byte_out, found) per item.
//   cfg_* channel writes prime_p (0), prime_q (1), modulus_n (2); always ready.
//   One item at a time: s_ready is high only while the sequencer is idle.
//   Every reduction runs on one shared restoring reducer.
//   Encrypt: one reduction of the squared input. Decrypt: two inverse searches
//   over the residues below p and q, two exponentiations of up to 2*log2(p)
//   reductions each, and up to four CRT candidates of one reduction each.
//   The result sits in an output register; the next item is accepted while
//   it waits. A finished item waiting behind a stalled m_ready holds the
//   sequencer until the output register frees.
//   Reset: synchronous aresetn low restores the reset primes and modulus
//   and empties the block.
// ----------------------------------------------------------------------------
module rabin_byte_cipher_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_mode,
    input  logic [rbc_pkg::BYTE_BITS-1:0]     s_plain_byte,
    input  rbc_pkg::word_t                    s_cipher_in,
    output logic                              m_valid,
    input  logic                              m_ready,
    output rbc_pkg::word_t                    m_cipher_out,
    output logic [rbc_pkg::BYTE_BITS-1:0]     m_byte_out,
    output logic                              m_found,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  rbc_pkg::word_t                    cfg_data
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_ENC_W  = 5'd1;
    localparam logic [4:0] S_IP_W   = 5'd2;
    localparam logic [4:0] S_IP_S   = 5'd3;
    localparam logic [4:0] S_IQ_W   = 5'd4;
    localparam logic [4:0] S_IQ_S   = 5'd5;
    localparam logic [4:0] S_PB_W   = 5'd6;
    localparam logic [4:0] S_PSTEP  = 5'd7;
    localparam logic [4:0] S_PACC_W = 5'd8;
    localparam logic [4:0] S_PSQ_W  = 5'd9;
    localparam logic [4:0] S_CA     = 5'd10;
    localparam logic [4:0] S_CB     = 5'd11;
    localparam logic [4:0] S_CM     = 5'd12;
    localparam logic [4:0] S_T1     = 5'd13;
    localparam logic [4:0] S_T2     = 5'd14;
    localparam logic [4:0] S_CRT_W  = 5'd15;
    localparam logic [4:0] S_OUT    = 5'd16;

    logic [4:0]           state_reg, state_next;
    rbc_pkg::prime_t      p_reg, q_reg;
    rbc_pkg::word_t       n_reg;
    rbc_pkg::word_t       c_reg, c_next;
    rbc_pkg::prime_t      ar_reg, ar_next, t_reg, t_next, i_reg, i_next;
    rbc_pkg::prime_t      ip_reg, ip_next, iq_reg, iq_next;
    rbc_pkg::exp_t        e_reg, e_next;
    rbc_pkg::prime_t      acc_reg, acc_next, bx_reg, bx_next;
    logic                 root_reg, root_next;
    rbc_pkg::prime_t      r1_reg, r1_next, r2_reg, r2_next;
    rbc_pkg::mod_t        ca_reg, ca_next, cb_reg, cb_next, mq_reg, mq_next;
    rbc_pkg::wide_t       sum_reg, sum_next;
    logic [1:0]           k_reg, k_next;
    rbc_pkg::word_t       res_cipher_reg, res_cipher_next;
    logic [rbc_pkg::BYTE_BITS-1:0] res_byte_reg, res_byte_next;
    logic                 res_found_reg, res_found_next;
    logic                 m_valid_reg, m_valid_next;
    rbc_pkg::word_t       m_cipher_reg;
    logic [rbc_pkg::BYTE_BITS-1:0] m_byte_reg;
    logic                 m_found_reg;
    logic                 out_load;

    rbc_pkg::mod_t        mul_a;
    rbc_pkg::mulb_t       mul_b;
    rbc_pkg::prod_t       mul_p;

    logic                 mod_start;
    rbc_pkg::wide_t       mod_x;
    rbc_pkg::mod_t        mod_m;
    rbc_pkg::mod_t        mod_r;
    rbc_pkg::mod_stat_t   mod_stat;

    rbc_pkg::prime_t      pm, sm, b1, b2;
    logic [rbc_pkg::PRIME_BITS:0] pp1, qp1, tsum;

    rbc_mod_unit u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start),
        .x       (mod_x),
        .m       (mod_m),
        .r       (mod_r),
        .stat    (mod_stat)
    );

    assign mul_p = rbc_pkg::prod_t'(mul_a) * rbc_pkg::prod_t'(mul_b);

    assign pm   = root_reg ? q_reg : p_reg;
    assign sm   = (state_reg == S_IQ_S) ? q_reg : p_reg;
    assign pp1  = {1'b0, p_reg} + 1'b1;
    assign qp1  = {1'b0, q_reg} + 1'b1;
    assign tsum = {1'b0, t_reg} + {1'b0, ar_reg};
    assign b1   = k_reg[0] ? p_reg - r1_reg : r1_reg;
    assign b2   = k_reg[1] ? q_reg - r2_reg : r2_reg;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_IDLE: begin
                mul_a = rbc_pkg::mod_t'({s_plain_byte, s_plain_byte});
                mul_b = rbc_pkg::mulb_t'({s_plain_byte, s_plain_byte});
            end
            S_PSTEP: begin
                mul_a = e_reg[0] ? rbc_pkg::mod_t'(acc_reg) : rbc_pkg::mod_t'(bx_reg);
                mul_b = rbc_pkg::mulb_t'(bx_reg);
            end
            S_PACC_W: begin
                mul_a = rbc_pkg::mod_t'(bx_reg);
                mul_b = rbc_pkg::mulb_t'(bx_reg);
            end
            S_CA: begin
                mul_a = rbc_pkg::mod_t'(ip_reg);
                mul_b = rbc_pkg::mulb_t'(q_reg);
            end
            S_CB: begin
                mul_a = rbc_pkg::mod_t'(iq_reg);
                mul_b = rbc_pkg::mulb_t'(p_reg);
            end
            S_CM: begin
                mul_a = rbc_pkg::mod_t'(p_reg);
                mul_b = rbc_pkg::mulb_t'(q_reg);
            end
            S_T1: begin
                mul_a = ca_reg;
                mul_b = rbc_pkg::mulb_t'(b1);
            end
            S_T2: begin
                mul_a = cb_reg;
                mul_b = rbc_pkg::mulb_t'(b2);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        c_next          = c_reg;
        ar_next         = ar_reg;
        t_next          = t_reg;
        i_next          = i_reg;
        ip_next         = ip_reg;
        iq_next         = iq_reg;
        e_next          = e_reg;
        acc_next        = acc_reg;
        bx_next         = bx_reg;
        root_next       = root_reg;
        r1_next         = r1_reg;
        r2_next         = r2_reg;
        ca_next         = ca_reg;
        cb_next         = cb_reg;
        mq_next         = mq_reg;
        sum_next        = sum_reg;
        k_next          = k_reg;
        res_cipher_next = res_cipher_reg;
        res_byte_next   = res_byte_reg;
        res_found_next  = res_found_reg;
        mod_start       = 1'b0;
        mod_x           = '0;
        mod_m           = '0;
        out_load        = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                res_cipher_next = '0;
                res_byte_next   = '0;
                res_found_next  = 1'b0;
                c_next          = s_cipher_in;
                if (s_valid) begin
                    if (!s_mode) begin
                        if (n_reg == '0) begin
                            res_found_next = 1'b1;
                            state_next     = S_OUT;
                        end else begin
                            mod_start  = 1'b1;
                            mod_x      = rbc_pkg::wide_t'(mul_p);
                            mod_m      = rbc_pkg::mod_t'(n_reg);
                            state_next = S_ENC_W;
                        end
                    end else if (p_reg == '0 || q_reg == '0) begin
                        state_next = S_OUT;
                    end else begin
                        mod_start  = 1'b1;
                        mod_x      = rbc_pkg::wide_t'(q_reg);
                        mod_m      = rbc_pkg::mod_t'(p_reg);
                        state_next = S_IP_W;
                    end
                end
            end
            S_ENC_W: begin
                if (mod_stat.done) begin
                    res_cipher_next = rbc_pkg::word_t'(mod_r);
                    res_found_next  = 1'b1;
                    state_next      = S_OUT;
                end
            end
            S_IP_W, S_IQ_W: begin
                if (mod_stat.done) begin
                    ar_next    = rbc_pkg::prime_t'(mod_r);
                    t_next     = rbc_pkg::prime_t'(mod_r);
                    i_next     = rbc_pkg::prime_t'(1);
                    state_next = (state_reg == S_IP_W) ? S_IP_S : S_IQ_S;
                end
            end
            S_IP_S, S_IQ_S: begin
                if (i_reg >= sm) begin
                    state_next = S_OUT;
                end else if (t_reg == rbc_pkg::prime_t'(1)) begin
                    mod_start = 1'b1;
                    if (state_reg == S_IP_S) begin
                        ip_next    = i_reg;
                        mod_x      = rbc_pkg::wide_t'(p_reg);
                        mod_m      = rbc_pkg::mod_t'(q_reg);
                        state_next = S_IQ_W;
                    end else begin
                        iq_next    = i_reg;
                        mod_x      = rbc_pkg::wide_t'(c_reg);
                        mod_m      = rbc_pkg::mod_t'(p_reg);
                        root_next  = 1'b0;
                        e_next     = rbc_pkg::exp_t'(pp1 >> 2);
                        acc_next   = rbc_pkg::prime_t'(1);
                        state_next = S_PB_W;
                    end
                end else begin
                    i_next = i_reg + 1'b1;
                    if (tsum >= {1'b0, sm}) begin
                        t_next = rbc_pkg::prime_t'(tsum - {1'b0, sm});
                    end else begin
                        t_next = rbc_pkg::prime_t'(tsum);
                    end
                end
            end
            S_PB_W: begin
                if (mod_stat.done) begin
                    bx_next    = rbc_pkg::prime_t'(mod_r);
                    state_next = S_PSTEP;
                end
            end
            S_PSTEP: begin
                if (e_reg == '0) begin
                    if (!root_reg) begin
                        r1_next    = acc_reg;
                        root_next  = 1'b1;
                        e_next     = rbc_pkg::exp_t'(qp1 >> 2);
                        acc_next   = rbc_pkg::prime_t'(1);
                        mod_start  = 1'b1;
                        mod_x      = rbc_pkg::wide_t'(c_reg);
                        mod_m      = rbc_pkg::mod_t'(q_reg);
                        state_next = S_PB_W;
                    end else begin
                        r2_next    = acc_reg;
                        state_next = S_CA;
                    end
                end else begin
                    mod_start = 1'b1;
                    mod_m     = rbc_pkg::mod_t'(pm);
                    if (e_reg[0]) begin
                        state_next = S_PACC_W;
                    end else begin
                        state_next = S_PSQ_W;
                    end
                    mod_x = rbc_pkg::wide_t'(mul_p);
                end
            end
            S_PACC_W: begin
                if (mod_stat.done) begin
                    acc_next   = rbc_pkg::prime_t'(mod_r);
                    mod_start  = 1'b1;
                    mod_x      = rbc_pkg::wide_t'(mul_p);
                    mod_m      = rbc_pkg::mod_t'(pm);
                    state_next = S_PSQ_W;
                end
            end
            S_PSQ_W: begin
                if (mod_stat.done) begin
                    bx_next    = rbc_pkg::prime_t'(mod_r);
                    e_next     = e_reg >> 1;
                    state_next = S_PSTEP;
                end
            end
            S_CA: begin
                ca_next    = rbc_pkg::mod_t'(mul_p);
                state_next = S_CB;
            end
            S_CB: begin
                cb_next    = rbc_pkg::mod_t'(mul_p);
                state_next = S_CM;
            end
            S_CM: begin
                mq_next    = rbc_pkg::mod_t'(mul_p);
                k_next     = 2'd0;
                state_next = S_T1;
            end
            S_T1: begin
                sum_next   = rbc_pkg::wide_t'(mul_p);
                state_next = S_T2;
            end
            S_T2: begin
                mod_start  = 1'b1;
                mod_x      = sum_reg + rbc_pkg::wide_t'(mul_p);
                mod_m      = mq_reg;
                state_next = S_CRT_W;
            end
            S_CRT_W: begin
                if (mod_stat.done) begin
                    if ((mod_r >> 16) == '0 && mod_r[7:0] == mod_r[15:8]) begin
                        res_byte_next  = mod_r[7:0];
                        res_found_next = 1'b1;
                        state_next     = S_OUT;
                    end else if (k_reg == 2'd3) begin
                        state_next = S_OUT;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_T1;
                    end
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            p_reg       <= rbc_pkg::RST_PRIME_P;
            q_reg       <= rbc_pkg::RST_PRIME_Q;
            n_reg       <= rbc_pkg::RST_MODULUS_N;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    rbc_pkg::CFG_PRIME_P:   p_reg <= cfg_data[rbc_pkg::PRIME_BITS-1:0];
                    rbc_pkg::CFG_PRIME_Q:   q_reg <= cfg_data[rbc_pkg::PRIME_BITS-1:0];
                    rbc_pkg::CFG_MODULUS_N: n_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        c_reg          <= c_next;
        ar_reg         <= ar_next;
        t_reg          <= t_next;
        i_reg          <= i_next;
        ip_reg         <= ip_next;
        iq_reg         <= iq_next;
        e_reg          <= e_next;
        acc_reg        <= acc_next;
        bx_reg         <= bx_next;
        root_reg       <= root_next;
        r1_reg         <= r1_next;
        r2_reg         <= r2_next;
        ca_reg         <= ca_next;
        cb_reg         <= cb_next;
        mq_reg         <= mq_next;
        sum_reg        <= sum_next;
        k_reg          <= k_next;
        res_cipher_reg <= res_cipher_next;
        res_byte_reg   <= res_byte_next;
        res_found_reg  <= res_found_next;
        if (out_load) begin
            m_cipher_reg <= res_cipher_reg;
            m_byte_reg   <= res_byte_reg;
            m_found_reg  <= res_found_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cipher_out = m_cipher_reg;
    assign m_byte_out   = m_byte_reg;
    assign m_found      = m_found_reg;

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_stat.busy |-> !s_ready) else $error("reducer busy while ready");
    a_byte_needs_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_byte_out == '0)) else $error("byte without found");
    a_cipher_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_cipher_out != '0) |-> m_found) else $error("cipher without found");
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("second transfer while busy");
`endif

endmodule
